[hw/rtl/gbc_pkg.sv]
package gbc_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W = COORD_W + 2;
  localparam int SHIFT_W = 5;
  localparam int DIM_W = 3;
  localparam int PAYLOAD_W = 32;
  localparam int INDEX_W = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int AXES = 3;
  localparam int AXIS_SEL_W = 2;

  localparam logic [DIM_W-1:0] MAX_GRID_X = 3'd4;
  localparam logic [DIM_W-1:0] MAX_GRID_Y = 3'd4;
  localparam logic [DIM_W-1:0] MAX_GRID_Z = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_SHIFT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_DEPTH = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0] lo;
    logic [DIM_W-1:0] hi;
    logic             empty;
  } axis_range_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                                input logic [DIM_W-1:0] maxd);
    eff_dim = (d > maxd) ? maxd : d;
  endfunction

endpackage

[hw/rtl/gbc_axis_unit.sv]
module gbc_axis_unit (
  input  logic signed [gbc_pkg::COORD_W-1:0] box_lo,
  input  logic signed [gbc_pkg::COORD_W-1:0] box_hi,
  input  logic signed [gbc_pkg::COORD_W-1:0] origin,
  input  logic        [gbc_pkg::SHIFT_W-1:0] shift,
  input  logic        [gbc_pkg::DIM_W-1:0]   dim,
  output gbc_pkg::axis_range_t               range
);
  import gbc_pkg::*;

  logic signed [DIFF_W-1:0] diff_lo;
  logic signed [DIFF_W-1:0] diff_hi_neg;
  logic signed [DIFF_W-1:0] start_cell;
  logic signed [DIFF_W-1:0] end_neg;
  logic signed [DIFF_W-1:0] end_cell;
  logic signed [DIFF_W-1:0] dim_s;
  logic signed [DIFF_W-1:0] start_clamped;
  logic signed [DIFF_W-1:0] end_clamped;

  assign diff_lo = DIFF_W'(box_lo) - DIFF_W'(origin);
  assign diff_hi_neg = DIFF_W'(origin) - DIFF_W'(box_hi);
  assign dim_s = $signed({{(DIFF_W-DIM_W){1'b0}}, dim});

  // floor for the start, ceiling for the end as the negated floor of the negation
  assign start_cell = diff_lo >>> shift;
  assign end_neg = diff_hi_neg >>> shift;
  assign end_cell = -end_neg;

  assign start_clamped = (start_cell < 0) ? '0 : start_cell;
  assign end_clamped = (end_cell > dim_s) ? dim_s : end_cell;

  always_comb begin
    range.empty = (start_clamped >= end_clamped);
    range.lo = start_clamped[DIM_W-1:0];
    range.hi = end_clamped[DIM_W-1:0];
  end

endmodule

[hw/rtl/grid_box_cell_cover_top.sv]
// The first cell of a box appears after three passes of the shared axis unit, one for x, y
// and z, and then a check state.
// Throughput: one covered cell per cycle while the output is not stalled; a box covers up to
// 64 cells. Input is stalled from acceptance until the last cell of the box is taken, or,
// for an empty cover, until the check state ends.
// Reset (synchronous, active high): sequencer idle, origins 0, cell_shift 8, dims 4.
module grid_box_cell_cover_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic        [gbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [gbc_pkg::COORD_W-1:0]     cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [gbc_pkg::COORD_W-1:0]     box_min_x,
  input  logic signed [gbc_pkg::COORD_W-1:0]     box_min_y,
  input  logic signed [gbc_pkg::COORD_W-1:0]     box_min_z,
  input  logic signed [gbc_pkg::COORD_W-1:0]     box_max_x,
  input  logic signed [gbc_pkg::COORD_W-1:0]     box_max_y,
  input  logic signed [gbc_pkg::COORD_W-1:0]     box_max_z,
  input  logic signed [gbc_pkg::PAYLOAD_W-1:0]   payload,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [gbc_pkg::INDEX_W-1:0]     cell_index,
  output logic signed [gbc_pkg::PAYLOAD_W-1:0]   cell_payload,
  output logic                                   last_cell
);
  import gbc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RANGE = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_WALK  = 2'd3;

  logic [1:0] state;

  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic [SHIFT_W-1:0] cell_shift;
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [DIM_W-1:0] grid_depth;

  logic signed [COORD_W-1:0] held_min [AXES];
  logic signed [COORD_W-1:0] held_max [AXES];
  logic signed [PAYLOAD_W-1:0] held_payload;

  logic [AXIS_SEL_W-1:0] axis;
  logic [DIM_W-1:0] range_lo [AXES];
  logic [DIM_W-1:0] range_hi [AXES];
  logic cover_empty;

  logic [DIM_W-1:0] walk_x;
  logic [DIM_W-1:0] walk_y;
  logic [DIM_W-1:0] walk_z;

  logic [DIM_W-1:0] dim_w;
  logic [DIM_W-1:0] dim_h;
  logic [DIM_W-1:0] dim_d;

  logic signed [COORD_W-1:0] unit_lo;
  logic signed [COORD_W-1:0] unit_hi;
  logic signed [COORD_W-1:0] unit_origin;
  logic [DIM_W-1:0] unit_dim;
  axis_range_t unit_range;

  logic in_take;
  logic out_take;
  logic x_end;
  logic y_end;
  logic z_end;
  logic [INDEX_W-1:0] yz_part;

  assign dim_w = eff_dim(grid_width, MAX_GRID_X);
  assign dim_h = eff_dim(grid_height, MAX_GRID_Y);
  assign dim_d = eff_dim(grid_depth, MAX_GRID_Z);

  always_comb begin
    unique case (axis)
      2'd0: begin
        unit_lo = held_min[0];
        unit_hi = held_max[0];
        unit_origin = origin_x;
        unit_dim = dim_w;
      end
      2'd1: begin
        unit_lo = held_min[1];
        unit_hi = held_max[1];
        unit_origin = origin_y;
        unit_dim = dim_h;
      end
      default: begin
        unit_lo = held_min[2];
        unit_hi = held_max[2];
        unit_origin = origin_z;
        unit_dim = dim_d;
      end
    endcase
  end

  gbc_axis_unit u_axis (
    .box_lo (unit_lo),
    .box_hi (unit_hi),
    .origin (unit_origin),
    .shift  (cell_shift),
    .dim    (unit_dim),
    .range  (unit_range)
  );

  assign in_stall = (state != S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_valid = (state == S_WALK);
  assign out_take = out_valid && !out_stall;

  assign x_end = (walk_x == range_hi[0] - 3'd1);
  assign y_end = (walk_y == range_hi[1] - 3'd1);
  assign z_end = (walk_z == range_hi[2] - 3'd1);

  assign yz_part = INDEX_W'(walk_y) + INDEX_W'(dim_h) * INDEX_W'(walk_z);
  assign cell_index = INDEX_W'(walk_x) + INDEX_W'(dim_w) * yz_part;
  assign cell_payload = held_payload;
  assign last_cell = x_end && y_end && z_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      cell_shift <= 5'd8;
      grid_width <= 3'd4;
      grid_height <= 3'd4;
      grid_depth <= 3'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    origin_x <= $signed(cfg_data);
        REG_ORIGIN_Y:    origin_y <= $signed(cfg_data);
        REG_ORIGIN_Z:    origin_z <= $signed(cfg_data);
        REG_CELL_SHIFT:  cell_shift <= cfg_data[SHIFT_W-1:0];
        REG_GRID_WIDTH:  grid_width <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        REG_GRID_DEPTH:  grid_depth <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_min[0] <= box_min_x;
      held_min[1] <= box_min_y;
      held_min[2] <= box_min_z;
      held_max[0] <= box_max_x;
      held_max[1] <= box_max_y;
      held_max[2] <= box_max_z;
      held_payload <= payload;
    end
    if (state == S_RANGE) begin
      range_lo[axis] <= unit_range.lo;
      range_hi[axis] <= unit_range.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= '0;
      cover_empty <= 1'b0;
      walk_x <= '0;
      walk_y <= '0;
      walk_z <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_RANGE;
            axis <= '0;
            cover_empty <= 1'b0;
          end
        end
        S_RANGE: begin
          cover_empty <= cover_empty || unit_range.empty;
          if (axis == AXIS_SEL_W'(AXES - 1)) begin
            state <= S_CHECK;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_CHECK: begin
          walk_x <= range_lo[0];
          walk_y <= range_lo[1];
          walk_z <= range_lo[2];
          state <= cover_empty ? S_IDLE : S_WALK;
        end
        S_WALK: begin
          if (out_take) begin
            if (last_cell) begin
              state <= S_IDLE;
            end else if (!z_end) begin
              walk_z <= walk_z + 3'd1;
            end else begin
              walk_z <= range_lo[2];
              if (!y_end) begin
                walk_y <= walk_y + 3'd1;
              end else begin
                walk_y <= range_lo[1];
                walk_x <= walk_x + 3'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (walk_x >= range_lo[0]) && (walk_x < range_hi[0]) &&
                  (walk_y >= range_lo[1]) && (walk_y < range_hi[1]) &&
                  (walk_z >= range_lo[2]) && (walk_z < range_hi[2]))
    else $error("walk left the cell range");

  a_accept_starts_range: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_RANGE) && (axis == '0))
    else $error("accepted box did not start range pass");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_cell) |=> !out_valid && !in_stall)
    else $error("walk continued past last cell");

  a_walk_needs_cover: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !cover_empty)
    else $error("empty cover produced a cell");

endmodule
